[rtl/rspd_pkg.sv]
package rspd_pkg;

    // default sizing of the block
    localparam int MAX_POINTS_PER_SIDE_DEF = 16;
    localparam int CONTROL_DEPTH_DEF       = 16;

    // fixed field widths
    localparam int IDX_W       = 7;
    localparam int DEF_W       = 32;
    localparam int LEN_W       = 31;
    localparam int PPS_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;

    // magnitude of a deformation difference, and the saturation input width
    localparam int SLOPE_W = 33;
    localparam int SAT_W   = 44;

    // width of signed base coordinates before deformation
    localparam int BASE_W = 34;

    // reset value of the points per side register
    localparam logic [PPS_W-1:0] PPS_RESET = PPS_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_UNCOVERED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_POINTS = 2'd2
    } t_cfg_reg;

    // perimeter sides in clockwise order from the corner (L/2, W/2)
    typedef enum logic [1:0] {
        SIDE_RIGHT  = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_TOP    = 2'd3
    } t_side;

    // clamp a wide signed value to 32-bit signed
    function automatic logic signed [DEF_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v[SAT_W-1:DEF_W-1] == '0 || v[SAT_W-1:DEF_W-1] == '1) begin
            return v[DEF_W-1:0];
        end else if (v[SAT_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

[rtl/rect_section_perimeter_deform.sv]
// Rectangular section perimeter sampler with piecewise-linear normal deformation.
// Input stream (s_axis): one item per operation; tuser carries the operation
// (clear table, append control point, query point), tdata the perimeter index
// and the displacement of an appended point.
// Output stream (m_axis): exactly one item per input item; tdata carries the
// deformed z, y and the deformation used, tuser the status code.
// Configuration channel (i_cfg_*): writes length, width and points per side;
// always ready; the user must write only while the block is idle (unchecked).
// Clear, append, unsupported operations and out-of-range queries answer in the
// cycle after they are accepted. A query scans the control table, one entry per
// cycle out of the table RAM, then runs the shared bit-serial divider once for the
// base point and once more for the segment slope when a segment covers the index.
// An in-range query may be accepted while the previous result still waits on
// m_axis; other items wait until the output register is free.
// Reset empties the control table, sets points per side to 16 and clears the
// output valid flag. A stalled receiver holds the result in place.
module rect_section_perimeter_deform
    import rspd_pkg::*;
#(
    parameter int MAX_POINTS_PER_SIDE = MAX_POINTS_PER_SIDE_DEF,
    parameter int CONTROL_DEPTH       = CONTROL_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // point_index[6:0], displacement[38:7], pad
    input  logic [OP_W-1:0]        s_axis_tuser,  // operation[1:0]
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // z_coord[31:0], y_coord[63:32],
                                                  // deform_amount[95:64]
    output logic [ST_W-1:0]        m_axis_tuser,  // status[1:0]
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [LEN_W-1:0]       i_cfg_data
);

    localparam int NW   = $clog2(MAX_POINTS_PER_SIDE + 1);
    localparam int TW   = $clog2(4 * MAX_POINTS_PER_SIDE + 1);
    localparam int CW   = (TW > IDX_W) ? TW : IDX_W;
    localparam int AW   = $clog2(CONTROL_DEPTH);
    localparam int CNTW = $clog2(CONTROL_DEPTH + 1);
    localparam int BPW  = LEN_W + NW;
    localparam int DW   = (BPW > SLOPE_W) ? BPW : SLOPE_W;
    localparam int VW   = TW;
    localparam int MPW  = SLOPE_W + CW;
    localparam int RAMW = IDX_W + DEF_W;

    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(CONTROL_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_BMUL  = 9'b000000100,
        S_BDIV  = 9'b000001000,
        S_SDIV  = 9'b000010000,
        S_DMUL  = 9'b000100000,
        S_DSAT  = 9'b001000000,
        S_COORD = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // configuration registers
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_wid;
    logic [PPS_W-1:0] r_pps;

    // sequencer and control table state
    t_state           r_state;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  r_k;
    logic             r_div_run;
    logic             r_found;

    // query datapath
    logic [CW-1:0]              r_idx;
    t_side                      r_sb;
    t_side                      r_ds;
    logic [NW-1:0]              r_kside;
    logic [CW-1:0]              r_p1;
    logic signed [DEF_W-1:0]    r_d1;
    logic [VW-1:0]              r_den;
    logic [CW-1:0]              r_off;
    logic                       r_neg;
    logic [SLOPE_W-1:0]         r_mag;
    logic [SLOPE_W-1:0]         r_slope;
    logic [BPW-1:0]             r_bprod;
    logic [MPW-1:0]             r_dprod;
    logic signed [DEF_W-1:0]    r_d;
    logic signed [BASE_W-1:0]   r_bz;
    logic signed [BASE_W-1:0]   r_by;
    logic signed [DEF_W-1:0]    r_z;
    logic signed [DEF_W-1:0]    r_y;

    // output register
    logic                       r_out_valid;
    logic signed [DEF_W-1:0]    r_out_z;
    logic signed [DEF_W-1:0]    r_out_y;
    logic signed [DEF_W-1:0]    r_out_d;
    t_status                    r_out_st;

    // combinational helpers
    logic [NW-1:0]              eff_sides;
    logic [CW-1:0]              side_n;
    logic [CW-1:0]              side_2n;
    logic [CW-1:0]              side_3n;
    logic [CW-1:0]              side_total;
    t_op                        in_op;
    logic [IDX_W-1:0]           in_idx;
    logic [CW-1:0]              in_idx_c;
    logic signed [DEF_W-1:0]    in_disp;
    logic                       is_long;
    logic                       out_free;
    logic                       out_load;
    logic                       acc;
    t_side                      in_sb;
    t_side                      in_ds;
    logic [CW-1:0]              in_koff;
    logic                       app_ok;
    logic [AW-1:0]              ram_raddr;
    logic [RAMW-1:0]            ram_rdata;
    logic [CW-1:0]              ent_idx;
    logic signed [DEF_W-1:0]    ent_def;
    logic                       at_end;
    logic [CW-1:0]              seg_p2;
    logic signed [DEF_W-1:0]    seg_d2;
    logic                       seg_test;
    logic                       hit;
    logic signed [SLOPE_W:0]    num;
    logic signed [SLOPE_W:0]    num_abs;
    logic [CNTW-1:0]            k_next;
    logic                       div_start;
    logic                       div_done;
    logic [DW-1:0]              div_dividend;
    logic [VW-1:0]              div_divisor;
    logic [DW-1:0]              div_q;
    logic [LEN_W-1:0]           side_len;
    logic signed [BASE_W-1:0]   hz_s;
    logic signed [BASE_W-1:0]   hy_s;
    logic signed [BASE_W-1:0]   q_s;
    logic signed [BASE_W-1:0]   bz_next;
    logic signed [BASE_W-1:0]   by_next;
    logic signed [SAT_W-1:0]    d_sum;
    logic signed [BASE_W-1:0]   d_ext;
    logic signed [BASE_W-1:0]   dz;
    logic signed [BASE_W-1:0]   dy;
    logic signed [BASE_W-1:0]   z_sum;
    logic signed [BASE_W-1:0]   y_sum;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_wid <= '0;
            r_pps <= PPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LENGTH: r_len <= i_cfg_data;
                CFG_WIDTH:  r_wid <= i_cfg_data;
                CFG_POINTS: r_pps <= i_cfg_data[PPS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective points per side and side boundaries
    always_comb begin
        if (r_pps == '0) begin
            eff_sides = NW'(1);
        end else if (32'(r_pps) > MAX_POINTS_PER_SIDE) begin
            eff_sides = NW'(MAX_POINTS_PER_SIDE);
        end else begin
            eff_sides = NW'(r_pps);
        end
        side_n     = CW'(eff_sides);
        side_2n    = side_n << 1;
        side_3n    = side_2n + side_n;
        side_total = side_n << 2;
    end

    // input item decode
    assign in_op    = t_op'(s_axis_tuser);
    assign in_idx   = s_axis_tdata[IDX_W-1:0];
    assign in_idx_c = CW'(in_idx);
    assign in_disp  = s_axis_tdata[IDX_W +: DEF_W];
    assign is_long  = (in_op == OP_QUERY) && (in_idx_c < side_total);
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && (is_long || out_free);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign app_ok   = (r_count < DEPTH_C) && (in_idx_c <= side_total);

    // output register loads on a short item or a finished query
    assign out_load = ((r_state == S_IDLE) && acc && !is_long)
                   || ((r_state == S_OUT) && out_free);

    // side of the base point (corners close a side) and side of the normal
    always_comb begin
        if (in_idx_c <= side_n) begin
            in_sb   = SIDE_RIGHT;
            in_koff = '0;
        end else if (in_idx_c <= side_2n) begin
            in_sb   = SIDE_BOTTOM;
            in_koff = side_n;
        end else if (in_idx_c <= side_3n) begin
            in_sb   = SIDE_LEFT;
            in_koff = side_2n;
        end else begin
            in_sb   = SIDE_TOP;
            in_koff = side_3n;
        end
        if (in_idx_c < side_n) begin
            in_ds = SIDE_RIGHT;
        end else if (in_idx_c < side_2n) begin
            in_ds = SIDE_BOTTOM;
        end else if (in_idx_c < side_3n) begin
            in_ds = SIDE_LEFT;
        end else begin
            in_ds = SIDE_TOP;
        end
    end

    // control table memory, one entry read per scan cycle
    assign k_next    = CNTW'(r_k + 1'b1);
    assign ram_raddr = (r_state == S_SCAN) ? k_next[AW-1:0] : '0;

    rspd_ram #(
        .WIDTH (RAMW),
        .DEPTH (CONTROL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (acc && (in_op == OP_APPEND) && app_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({in_disp, in_idx}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // segment test against the entry read this cycle or the closing point
    always_comb begin
        ent_idx  = CW'(ram_rdata[IDX_W-1:0]);
        ent_def  = ram_rdata[RAMW-1:IDX_W];
        at_end   = (r_k == r_count);
        seg_p2   = at_end ? side_total : ent_idx;
        seg_d2   = at_end ? '0 : ent_def;
        seg_test = at_end ? (r_count != '0) : (r_k != '0);
        hit      = seg_test && (r_p1 <= r_idx) && (r_idx < seg_p2);
        num      = (SLOPE_W + 1)'(r_d1) - (SLOPE_W + 1)'(seg_d2);
        num_abs  = num[SLOPE_W] ? -num : num;
    end

    // shared divider: base step first, then the segment slope
    assign div_start    = ((r_state == S_BDIV) || (r_state == S_SDIV)) && !r_div_run;
    assign div_dividend = (r_state == S_SDIV) ? DW'(r_mag) : DW'(r_bprod);
    assign div_divisor  = (r_state == S_SDIV) ? r_den : VW'(eff_sides);

    rspd_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // base point from the divided side step
    assign side_len = ((r_sb == SIDE_BOTTOM) || (r_sb == SIDE_TOP)) ? r_len : r_wid;

    always_comb begin
        hz_s = $signed({{(BASE_W - LEN_W + 1){1'b0}}, r_len[LEN_W-1:1]});
        hy_s = $signed({{(BASE_W - LEN_W + 1){1'b0}}, r_wid[LEN_W-1:1]});
        q_s  = $signed({{(BASE_W - LEN_W){1'b0}}, div_q[LEN_W-1:0]});
        case (r_sb)
            SIDE_RIGHT: begin
                bz_next = hz_s;
                by_next = hy_s - q_s;
            end
            SIDE_BOTTOM: begin
                bz_next = hz_s - q_s;
                by_next = -hy_s;
            end
            SIDE_LEFT: begin
                bz_next = -hz_s;
                by_next = q_s - hy_s;
            end
            default: begin
                bz_next = q_s - hz_s;
                by_next = hy_s;
            end
        endcase
    end

    // interpolated deformation and its normal direction
    always_comb begin
        if (r_neg) begin
            d_sum = SAT_W'(r_d1) + SAT_W'($signed({1'b0, r_dprod}));
        end else begin
            d_sum = SAT_W'(r_d1) - SAT_W'($signed({1'b0, r_dprod}));
        end
        d_ext = BASE_W'(r_d);
        dz    = '0;
        dy    = '0;
        case (r_ds)
            SIDE_RIGHT:  dz = d_ext;
            SIDE_BOTTOM: dy = -d_ext;
            SIDE_LEFT:   dz = -d_ext;
            default:     dy = d_ext;
        endcase
        z_sum = r_bz + dz;
        y_sum = r_by + dy;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_div_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && is_long) begin
                        r_state <= S_SCAN;
                    end else if (acc) begin
                        if (in_op == OP_CLEAR) begin
                            r_count <= '0;
                        end else if ((in_op == OP_APPEND) && app_ok) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit || at_end) begin
                        r_state <= S_BMUL;
                    end
                end
                S_BMUL: begin
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (div_done) begin
                        r_div_run <= 1'b0;
                        r_state   <= r_found ? S_SDIV : S_COORD;
                    end
                end
                S_SDIV: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (div_done) begin
                        r_div_run <= 1'b0;
                        r_state   <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    r_state <= S_DSAT;
                end
                S_DSAT: begin
                    r_state <= S_COORD;
                end
                S_COORD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // query datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_idx   <= in_idx_c;
                r_sb    <= in_sb;
                r_ds    <= in_ds;
                r_kside <= NW'(in_idx_c - in_koff);
                r_k     <= '0;
                r_d     <= '0;
                r_found <= 1'b0;
            end
            S_SCAN: begin
                if (hit) begin
                    r_found <= 1'b1;
                    r_den   <= VW'(seg_p2 - r_p1);
                    r_off   <= r_idx - r_p1;
                    r_neg   <= num[SLOPE_W];
                    r_mag   <= num_abs[SLOPE_W-1:0];
                end else if (!at_end) begin
                    r_p1 <= ent_idx;
                    r_d1 <= ent_def;
                    r_k  <= k_next;
                end
            end
            S_BMUL: begin
                r_bprod <= BPW'(side_len) * BPW'(r_kside);
            end
            S_BDIV: begin
                if (div_done) begin
                    r_bz <= bz_next;
                    r_by <= by_next;
                end
            end
            S_SDIV: begin
                if (div_done) begin
                    r_slope <= div_q[SLOPE_W-1:0];
                end
            end
            S_DMUL: begin
                r_dprod <= MPW'(r_slope) * MPW'(r_off);
            end
            S_DSAT: begin
                r_d <= sat32(d_sum);
            end
            S_COORD: begin
                r_z <= sat32(SAT_W'(z_sum));
                r_y <= sat32(SAT_W'(y_sum));
            end
            default: ;
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && acc && !is_long) begin
            r_out_z <= '0;
            r_out_y <= '0;
            r_out_d <= '0;
            unique case (in_op)
                OP_APPEND: begin
                    if (r_count >= DEPTH_C) begin
                        r_out_st <= ST_FULL;
                    end else if (in_idx_c > side_total) begin
                        r_out_st <= ST_RANGE;
                    end else begin
                        r_out_st <= ST_OK;
                    end
                end
                OP_QUERY: r_out_st <= ST_RANGE;
                default:  r_out_st <= ST_OK;
            endcase
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_z  <= r_z;
            r_out_y  <= r_y;
            r_out_d  <= r_d;
            r_out_st <= r_found ? ST_OK : ST_UNCOVERED;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_d, r_out_y, r_out_z};
    assign m_axis_tuser  = r_out_st;

`ifndef SYNTHESIS
    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_long) |=> (r_state == S_SCAN))
        else $error("query item did not start the table scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("control point count beyond table depth");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_BDIV) || (r_state == S_SDIV)))
        else $error("divider finished outside a divide step");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("query result not loaded into the output register");
`endif

endmodule

[rtl/rspd_ram.sv]
module rspd_ram
    import rspd_pkg::*;
#(
    parameter int WIDTH = IDX_W + DEF_W,
    parameter int DEPTH = CONTROL_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rspd_div.sv]
module rspd_div
    import rspd_pkg::*;
#(
    parameter int DW = 36,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_den;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             q_bit;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_den};
        q_bit = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], q_bit};
            r_rem <= q_bit ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[bench/tb_rect_section_perimeter_deform.sv]
module tb_rect_section_perimeter_deform;
    import rspd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -Q_MAX - 1;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     PHASE_ITEMS = 170;

    // one input item and one result item
    typedef struct {
        t_op                op;
        logic [IDX_W-1:0]   index;
        logic signed [31:0] disp;
    } t_deform_cmd;

    typedef struct {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] d;
        t_status            status;
    } t_perimeter_point;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // point_index[6:0], displacement[38:7], pad
    logic [OP_W-1:0]        s_axis_tuser = '0;   // operation[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // z_coord, y_coord, deform_amount
    logic [ST_W-1:0]        m_axis_tuser;        // status[1:0]
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [LEN_W-1:0]       i_cfg_data = '0;

    rect_section_perimeter_deform i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow of the section registers and the control table
    longint           sec_length = 0;
    longint           sec_width  = 0;
    logic [PPS_W-1:0] sec_points = PPS_RESET;
    longint           table_index [CONTROL_DEPTH_DEF];
    longint           table_deform [CONTROL_DEPTH_DEF];
    int               table_count = 0;

    t_deform_cmd      cmd_queue[$];
    t_perimeter_point expected_points[$];
    t_deform_cmd      cur_cmd;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               fail_count     = 0;
    int               cycle_count    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp_q16(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // effective sample steps per side after clamping
    function automatic longint points_eff();
        if (sec_points == 0) return 1;
        if (sec_points > MAX_POINTS_PER_SIDE_DEF) return MAX_POINTS_PER_SIDE_DEF;
        return longint'(sec_points);
    endfunction

    // apply one item to the shadow table and work out its result
    function automatic t_perimeter_point compute_perimeter_point(t_deform_cmd c);
        t_perimeter_point pt;
        longint n, total, idx, hz, hy, z, y, d, p1, p2, d1, d2, slope;
        bit hit;
        pt.z = '0;
        pt.y = '0;
        pt.d = '0;
        pt.status = ST_OK;
        n = points_eff();
        total = 4 * n;
        idx = longint'(c.index);
        z = 0;
        y = 0;
        d = 0;
        hit = 1'b0;
        case (c.op)
            OP_CLEAR: begin
                table_count = 0;
            end
            OP_APPEND: begin
                if (table_count >= CONTROL_DEPTH_DEF) begin
                    pt.status = ST_FULL;
                end else if (idx > total) begin
                    pt.status = ST_RANGE;
                end else begin
                    table_index[table_count] = idx;
                    table_deform[table_count] = longint'(c.disp);
                    table_count++;
                end
            end
            OP_QUERY: begin
                if (idx >= total) begin
                    pt.status = ST_RANGE;
                end else begin
                    // base point, clockwise from the top right corner
                    hz = sec_length / 2;
                    hy = sec_width / 2;
                    if (idx <= n) begin
                        z = hz;
                        y = hy - (sec_width * idx) / n;
                    end else if (idx <= 2 * n) begin
                        z = hz - (sec_length * (idx - n)) / n;
                        y = -hy;
                    end else if (idx <= 3 * n) begin
                        z = -hz;
                        y = -hy + (sec_width * (idx - 2 * n)) / n;
                    end else begin
                        z = -hz + (sec_length * (idx - 3 * n)) / n;
                        y = hy;
                    end
                    // first segment in append order that covers the index
                    for (int k = 0; k < table_count && !hit; k++) begin
                        p1 = table_index[k];
                        d1 = table_deform[k];
                        if (k + 1 < table_count) begin
                            p2 = table_index[k + 1];
                            d2 = table_deform[k + 1];
                        end else begin
                            p2 = total;
                            d2 = 0;
                        end
                        if (p1 <= idx && idx < p2) begin
                            slope = (d1 - d2) / (p2 - p1);
                            d = clamp_q16(d1 - slope * (idx - p1));
                            hit = 1'b1;
                        end
                    end
                    if (!hit) pt.status = ST_UNCOVERED;
                    // displace normal to the side
                    if (idx < n) z += d;
                    else if (idx < 2 * n) y -= d;
                    else if (idx < 3 * n) z -= d;
                    else y += d;
                    pt.z = 32'(clamp_q16(z));
                    pt.y = 32'(clamp_q16(y));
                    pt.d = 32'(d);
                end
            end
            default: ;
        endcase
        return pt;
    endfunction

    // source of input items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_points.insert(expected_points.size(),
                                       compute_perimeter_point(cur_cmd));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, cur_cmd.disp, cur_cmd.index};
                    s_axis_tuser  <= cur_cmd.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_perimeter_point want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_points.size() == 0) begin
                    $error("result item with no expected item pending");
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    compare_field("z_coord", want.z, m_axis_tdata[31:0]);
                    compare_field("y_coord", want.y, m_axis_tdata[63:32]);
                    compare_field("deform_amount", want.d, m_axis_tdata[95:64]);
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg r, logic [LEN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            CFG_LENGTH: sec_length = longint'(v);
            CFG_WIDTH:  sec_width  = longint'(v);
            CFG_POINTS: sec_points = v[PPS_W-1:0];
            default: ;
        endcase
    endtask

    // block is idle once every item went in and every result came out
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic configure_phase(logic [LEN_W-1:0] l, logic [LEN_W-1:0] w,
                                   logic [PPS_W-1:0] n, int s_idle, int r_stall);
        wait_drained();
        write_reg(CFG_LENGTH, l);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_POINTS, LEN_W'(n));
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
    endtask

    task automatic push_cmd(t_op op, int idx, logic signed [31:0] disp);
        t_deform_cmd c;
        c.op    = op;
        c.index = idx[IDX_W-1:0];
        c.disp  = disp;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    function automatic logic signed [31:0] rand_disp();
        case ($urandom_range(9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3, 4: return $signed($urandom_range(32'h000f_ffff)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int query_index(int total);
        if ($urandom_range(9) == 0) return $urandom_range(127);
        return $urandom_range(total - 1);
    endfunction

    // mostly clear / append / query runs, some table overflow and raw noise
    task automatic push_random_items(int count);
        int issued, total, k, nq, roll;
        int pts[$];
        issued = 0;
        total = int'(4 * points_eff());
        while (issued < count) begin
            roll = $urandom_range(99);
            pts.delete();
            if (roll < 65) begin
                if (roll >= 8) begin
                    push_cmd(OP_CLEAR, $urandom_range(127), rand_disp());
                    issued++;
                end
                k = $urandom_range(16, 1);
                for (int j = 0; j < k; j++) pts.insert(pts.size(), $urandom_range(total, 0));
                pts.sort();
                if ($urandom_range(1) == 1) pts[0] = 0;
                foreach (pts[j]) push_cmd(OP_APPEND, pts[j], rand_disp());
                nq = $urandom_range(10, 2);
                for (int j = 0; j < nq; j++) push_cmd(OP_QUERY, query_index(total), rand_disp());
                issued += k + nq;
            end else if (roll < 80) begin
                // fill the table and push past its end
                push_cmd(OP_CLEAR, 0, 0);
                k = CONTROL_DEPTH_DEF + $urandom_range(3, 1);
                for (int j = 0; j < k; j++) pts.insert(pts.size(), $urandom_range(total, 0));
                pts.sort();
                foreach (pts[j]) push_cmd(OP_APPEND, pts[j], rand_disp());
                nq = $urandom_range(6, 2);
                for (int j = 0; j < nq; j++) push_cmd(OP_QUERY, query_index(total), rand_disp());
                issued += 1 + k + nq;
            end else begin
                nq = $urandom_range(8, 1);
                for (int j = 0; j < nq; j++)
                    push_cmd(t_op'($urandom_range(3)), $urandom_range(127), rand_disp());
                issued += nq;
            end
        end
    endtask

    // stimulus phases
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: 10.0 by 6.0, four steps per side
        configure_phase(31'h000a_0000, 31'h0006_0000, 5'd4, 0, 0);
        push_cmd(OP_QUERY, 5, 0);                    // empty table
        push_cmd(OP_APPEND, 3, 32'sh0064_0000);
        push_cmd(OP_QUERY, 1, 0);                    // before the first control point
        push_cmd(OP_QUERY, 3, 0);
        push_cmd(OP_QUERY, 15, 0);                   // segment to the closing point
        push_cmd(OP_APPEND, 16, 32'sh8000_0000);     // index equal to 4N is stored
        push_cmd(OP_APPEND, 17, 1);                  // past 4N
        push_cmd(OP_APPEND, 127, -1);
        push_cmd(OP_QUERY, 9, 0);
        push_cmd(OP_QUERY, 16, 0);                   // query at 4N
        push_cmd(OP_QUERY, 127, -1);
        push_cmd(OP_NONE, 127, 32'sh7fff_ffff);
        push_cmd(OP_APPEND, 8, 32'sh7fff_ffff);      // backward segment covers nothing
        push_cmd(OP_QUERY, 0, 0);
        push_cmd(OP_QUERY, 12, 0);
        push_cmd(OP_CLEAR, 127, -1);
        push_cmd(OP_APPEND, 0, 32'sh7fff_ffff);
        push_cmd(OP_QUERY, 0, 0);
        push_cmd(OP_QUERY, 4, 0);                    // corners
        push_cmd(OP_QUERY, 8, 0);
        push_cmd(OP_QUERY, 13, 0);
        push_random_items(PHASE_ITEMS);

        configure_phase(31'h0, 31'h0, 5'd1, 50, 0);
        push_random_items(PHASE_ITEMS);

        configure_phase(31'h7fff_ffff, 31'h7fff_ffff, 5'd16, 0, 50);
        push_random_items(PHASE_ITEMS);

        configure_phase(LEN_W'($urandom), LEN_W'($urandom), 5'd0, 21, 21); // zero steps act as one
        push_random_items(PHASE_ITEMS);

        configure_phase(31'h7fff_ffff, 31'h1, 5'd31, 0, 0);      // above the maximum
        push_random_items(PHASE_ITEMS);

        configure_phase(LEN_W'($urandom_range(32'h00ff_ffff)),
                        LEN_W'($urandom_range(32'h00ff_ffff)),
                        5'($urandom_range(15, 2)), 50, 0);
        push_random_items(PHASE_ITEMS);

        configure_phase(LEN_W'($urandom), LEN_W'($urandom_range(32'h00ff_ffff)),
                        5'd17, 0, 50);
        push_random_items(PHASE_ITEMS);

        configure_phase(LEN_W'($urandom_range(32'h00ff_ffff)), LEN_W'($urandom),
                        5'd16, 21, 21);
        push_random_items(PHASE_ITEMS);

        // drain and let the last query finish
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
